/* rtl/core/arp_request_responder_assert.svh */
// assertion helpers for the arp responder, clocked on clk and held off during reset
`ifndef ARP_REQUEST_RESPONDER_ASSERT_SVH
`define ARP_REQUEST_RESPONDER_ASSERT_SVH

// property must hold at every edge out of reset
`define ARP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen out of reset
`define ARP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* rtl/core/arp_pkg.sv */
package arp_pkg;

    localparam int HDR_LEN         = 42;
    localparam int CNT_W           = 6;
    localparam int FRAME_W         = HDR_LEN * 8;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd1;

    localparam logic [15:0] ETH_TYPE_ARP     = 16'h0806;
    localparam logic [15:0] ETH_TYPE_IPV4    = 16'h0800;
    localparam logic [15:0] ARP_HTYPE_ETH    = 16'h0001;
    localparam logic [15:0] ARP_OPER_REQUEST = 16'h0001;
    localparam logic [15:0] ARP_OPER_REPLY   = 16'h0002;
    localparam logic [7:0]  ARP_HLEN         = 8'd6;
    localparam logic [7:0]  ARP_PLEN         = 8'd4;

    // byte offsets inside the received header
    localparam logic [CNT_W-1:0] POS_ETH_SRC  = 6'd6;
    localparam logic [CNT_W-1:0] POS_ETH_TYPE = 6'd12;
    localparam logic [CNT_W-1:0] POS_ETH_END  = 6'd14;
    localparam logic [CNT_W-1:0] POS_OPER     = 6'd20;
    localparam logic [CNT_W-1:0] POS_SHA      = 6'd22;
    localparam logic [CNT_W-1:0] POS_SPA      = 6'd28;
    localparam logic [CNT_W-1:0] POS_SPA_END  = 6'd32;
    localparam logic [CNT_W-1:0] POS_TPA      = 6'd38;
    localparam logic [CNT_W-1:0] POS_HDR_END  = 6'd42;
    localparam logic [CNT_W-1:0] POS_LAST     = 6'd41;

    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] sha;
        logic [31:0] spa;
        logic        reply;
    } arp_desc_t;

    typedef struct packed {
        logic      push;
        arp_desc_t desc;
    } arp_push_t;

    typedef struct packed {
        logic      valid;
        arp_desc_t desc;
    } arp_head_t;

    typedef enum logic {
        TX_IDLE,
        TX_REPLY
    } arp_tx_state_t;

endpackage

/* rtl/core/arp_request_responder.sv */
// channel   direction  transfer when                 payload
// frame in  in         start && !busy                rx_byte, frame_end
// result    out        strobe (one cycle, no stall)  kind, reply_byte, sender_ip,
//                                                    learn_mac, run_last
// config    in         cfg_valid && cfg_ready        cfg_index, cfg_data
//
// the front takes one frame byte per cycle while start is high and busy is low
// the back emits one result per cycle: 1 result for a learn-only frame, 43 with a reply
// a QUEUE_DEPTH-entry descriptor queue (default 2) between them; busy while full
// after the final byte, a free back pops the queue into its output registers
// rst_n clears counters, queue, back state and both address registers to zero
module arp_request_responder #(
    parameter int QUEUE_DEPTH = arp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [7:0]                      rx_byte,
    input  logic                            frame_end,
    output logic                            strobe,
    output logic                            kind,
    output logic [7:0]                      reply_byte,
    output logic [31:0]                     sender_ip,
    output logic [47:0]                     learn_mac,
    output logic                            run_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [arp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [47:0]                     cfg_data
);
    import arp_pkg::*;

    logic [31:0] own_ip_reg;
    logic [47:0] own_mac_reg;
    logic        accept;
    logic        pop;
    logic        full;
    arp_push_t   push;
    arp_head_t   head;

    assign cfg_ready = 1'b1;
    assign busy      = full;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_OWN_IP)
                own_ip_reg <= cfg_data[31:0];
            else if (cfg_index == CFG_OWN_MAC)
                own_mac_reg <= cfg_data;
        end
    end

    arp_rx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .frame_end (frame_end),
        .own_ip    (own_ip_reg),
        .push      (push)
    );

    arp_desc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (full)
    );

    arp_tx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .own_ip     (own_ip_reg),
        .own_mac    (own_mac_reg),
        .pop        (pop),
        .strobe     (strobe),
        .kind       (kind),
        .reply_byte (reply_byte),
        .sender_ip  (sender_ip),
        .learn_mac  (learn_mac),
        .run_last   (run_last)
    );

endmodule

/* rtl/core/arp_rx_front.sv */
module arp_rx_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  logic              frame_end,
    input  logic [31:0]       own_ip,
    output arp_pkg::arp_push_t push
);
    import arp_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [47:0]      eth_src_reg, eth_src_next;
    logic [15:0]      eth_type_reg, eth_type_next;
    logic [15:0]      oper_reg, oper_next;
    logic [47:0]      sha_reg, sha_next;
    logic [31:0]      spa_reg, spa_next;
    logic [31:0]      tpa_reg, tpa_next;
    logic [31:0]      tpa_now;
    logic             hdr_full;

    always_comb
    begin
        count_next    = count_reg;
        eth_src_next  = eth_src_reg;
        eth_type_next = eth_type_reg;
        oper_next     = oper_reg;
        sha_next      = sha_reg;
        spa_next      = spa_reg;
        tpa_next      = tpa_reg;
        if (accept)
        begin
            if (count_reg < POS_HDR_END)
            begin
                count_next = count_reg + 6'd1;
                if (count_reg >= POS_ETH_SRC && count_reg < POS_ETH_TYPE)
                    eth_src_next = {eth_src_reg[39:0], rx_byte};
                if (count_reg >= POS_ETH_TYPE && count_reg < POS_ETH_END)
                    eth_type_next = {eth_type_reg[7:0], rx_byte};
                if (count_reg >= POS_OPER && count_reg < POS_SHA)
                    oper_next = {oper_reg[7:0], rx_byte};
                if (count_reg >= POS_SHA && count_reg < POS_SPA)
                    sha_next = {sha_reg[39:0], rx_byte};
                if (count_reg >= POS_SPA && count_reg < POS_SPA_END)
                    spa_next = {spa_reg[23:0], rx_byte};
                if (count_reg >= POS_TPA)
                    tpa_next = {tpa_reg[23:0], rx_byte};
            end
            if (frame_end)
                count_next = '0;
        end
    end

    // the final target ip byte may arrive together with frame_end
    assign tpa_now  = (count_reg == POS_LAST) ? {tpa_reg[23:0], rx_byte} : tpa_reg;
    assign hdr_full = (count_reg >= POS_LAST);

    always_comb
    begin
        push.push         = accept && frame_end && hdr_full && (eth_type_reg == ETH_TYPE_ARP);
        push.desc.dst_mac = eth_src_reg;
        push.desc.sha     = sha_reg;
        push.desc.spa     = spa_reg;
        push.desc.reply   = (oper_reg == ARP_OPER_REQUEST) && (tpa_now == own_ip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        eth_src_reg  <= eth_src_next;
        eth_type_reg <= eth_type_next;
        oper_reg     <= oper_next;
        sha_reg      <= sha_next;
        spa_reg      <= spa_next;
        tpa_reg      <= tpa_next;
    end

endmodule

/* rtl/core/arp_desc_queue.sv */
module arp_desc_queue #(
    parameter int DEPTH = arp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  arp_pkg::arp_push_t push,
    input  logic               pop,
    output arp_pkg::arp_head_t head,
    output logic               full
);
    import arp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    arp_desc_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             do_push;
    logic             do_pop;

    assign do_push = push.push && !full;
    assign do_pop  = pop && (occ_reg != '0);
    assign full    = (occ_reg == OCC_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        occ_next    = occ_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        case ({do_push, do_pop})
            2'b10:   occ_next = occ_reg + OCC_W'(1);
            2'b01:   occ_next = occ_reg - OCC_W'(1);
            default: occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.desc;
    end

    assign head.valid = (occ_reg != '0);
    assign head.desc  = mem_reg[rd_ptr_reg];

endmodule

/* rtl/core/arp_tx_back.sv */
`include "arp_request_responder_assert.svh"

module arp_tx_back (
    input  logic               clk,
    input  logic               rst_n,
    input  arp_pkg::arp_head_t head,
    input  logic [31:0]        own_ip,
    input  logic [47:0]        own_mac,
    output logic               pop,
    output logic               strobe,
    output logic               kind,
    output logic [7:0]         reply_byte,
    output logic [31:0]        sender_ip,
    output logic [47:0]        learn_mac,
    output logic               run_last
);
    import arp_pkg::*;

    arp_tx_state_t      state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic               strobe_reg, strobe_next;
    logic               kind_reg, kind_next;
    logic [7:0]         reply_byte_reg, reply_byte_next;
    logic [31:0]        sender_ip_reg, sender_ip_next;
    logic [47:0]        learn_mac_reg, learn_mac_next;
    logic               run_last_reg, run_last_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TX_IDLE:
            begin
                if (head.valid && head.desc.reply)
                    state_next = TX_REPLY;
            end
            TX_REPLY:
            begin
                if (idx_reg == POS_LAST)
                    state_next = TX_IDLE;
            end
            default: state_next = TX_IDLE;
        endcase
    end

    always_comb
    begin
        pop             = 1'b0;
        idx_next        = idx_reg;
        frame_next      = frame_reg;
        strobe_next     = 1'b0;
        kind_next       = 1'b0;
        reply_byte_next = 8'h00;
        sender_ip_next  = 32'h0;
        learn_mac_next  = 48'h0;
        run_last_next   = 1'b0;
        case (state_reg)
            TX_IDLE:
            begin
                if (head.valid)
                begin
                    pop             = 1'b1;
                    strobe_next     = 1'b1;
                    sender_ip_next  = head.desc.spa;
                    learn_mac_next  = head.desc.sha;
                    run_last_next   = !head.desc.reply;
                    idx_next        = '0;
                    // whole reply frame in wire order, shifted out from the top
                    frame_next = {head.desc.dst_mac, own_mac, ETH_TYPE_ARP,
                                  ARP_HTYPE_ETH, ETH_TYPE_IPV4, ARP_HLEN, ARP_PLEN,
                                  ARP_OPER_REPLY, own_mac, own_ip,
                                  head.desc.sha, head.desc.spa};
                end
            end
            TX_REPLY:
            begin
                strobe_next     = 1'b1;
                kind_next       = 1'b1;
                reply_byte_next = frame_reg[FRAME_W-1 -: 8];
                run_last_next   = (idx_reg == POS_LAST);
                frame_next      = {frame_reg[FRAME_W-9:0], 8'h00};
                idx_next        = idx_reg + 6'd1;
            end
            default: pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= TX_IDLE;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg      <= frame_next;
        kind_reg       <= kind_next;
        reply_byte_reg <= reply_byte_next;
        sender_ip_reg  <= sender_ip_next;
        learn_mac_reg  <= learn_mac_next;
        run_last_reg   <= run_last_next;
    end

    assign strobe     = strobe_reg;
    assign kind       = kind_reg;
    assign reply_byte = reply_byte_reg;
    assign sender_ip  = sender_ip_reg;
    assign learn_mac  = learn_mac_reg;
    assign run_last   = run_last_reg;

    `ARP_ASSERT(a_pop_gives_learn, pop |=> (strobe && !kind), "pop without learn record")
    `ARP_ASSERT_NEVER(a_no_pop_in_reply, state_reg == TX_REPLY && pop, "pop during reply")
    `ARP_ASSERT(a_reply_closes_run,
                (state_reg == TX_REPLY && idx_reg == POS_LAST) |=> (strobe && kind && run_last),
                "reply run not closed")
    `ARP_ASSERT(a_learn_only_last,
                (pop && !head.desc.reply) |=> (run_last && state_reg == TX_IDLE),
                "learn-only frame not closed")

endmodule
